// ----- src/awpid_pkg.sv -----
// Package with the widths, reset values, register codes and saturating helpers of the PID unit.
`default_nettype none
package awpid_pkg;

  // Binary point position of gains and signals.
  localparam int FRAC_BITS = 16;

  localparam int GAIN_W = 32;                // gain registers, signed Q(31-F).F
  localparam int SIG_W  = 24;                // sample and limit fields, signed Q(23-F).F
  localparam int ACC_W  = 32;                // saturated internal sums and state
  localparam int ERR_W  = SIG_W + 1;         // reference - measured_position never overflows
  localparam int DIFF_W = ERR_W + 1;         // difference of two errors
  localparam int IDX_W  = 3;                 // configuration register index

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_WINDUP_GAIN   = 3'd2,
    REG_DERIV_POLE    = 3'd3,
    REG_DERIV_GAIN    = 3'd4,
    REG_UPPER_LIMIT   = 3'd5,
    REG_LOWER_LIMIT   = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST     = 32'sd3932160;
  localparam logic signed [GAIN_W-1:0] INTEGRAL_GAIN_RST = 32'sd299593;
  localparam logic signed [GAIN_W-1:0] WINDUP_GAIN_RST   = 32'sd13107;
  localparam logic signed [GAIN_W-1:0] DERIV_POLE_RST    = 32'sd9237;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST    = 32'sd11083941;
  localparam logic signed [SIG_W-1:0]  UPPER_LIMIT_RST   = 24'sd196608;
  localparam logic signed [SIG_W-1:0]  LOWER_LIMIT_RST   = -24'sd196608;

  // a + b, clamped to the signed accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  // a - b, clamped to the signed accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_sub = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_sub = s[ACC_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/awpid_ifs.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none
interface awpid_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [awpid_pkg::SIG_W-1:0]   reference;
  logic signed [awpid_pkg::SIG_W-1:0]   measured_position;
  modport source (output valid, reference, measured_position, input ready);
  modport sink   (input valid, reference, measured_position, output ready);
endinterface

interface awpid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [awpid_pkg::SIG_W-1:0]   drive_value;
  logic                                 clipped;
  modport source (output valid, drive_value, clipped, input ready);
  modport sink   (input valid, drive_value, clipped, output ready);
endinterface

interface awpid_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [awpid_pkg::IDX_W-1:0]          index;
  logic [awpid_pkg::GAIN_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/awpid_fmul.sv -----
// Fixed-point gain times signal with floor scaling and saturation to the accumulator range.
`default_nettype none
module awpid_fmul (
  input  wire logic signed [awpid_pkg::GAIN_W-1:0] gain,
  input  wire logic signed [awpid_pkg::ACC_W-1:0]  sig,
  output logic signed [awpid_pkg::ACC_W-1:0]       prod
);

  localparam int PROD_W = awpid_pkg::GAIN_W + awpid_pkg::ACC_W;

  logic signed [PROD_W-1:0] full;
  logic signed [PROD_W-1:0] scaled;

  // Arithmetic right shift rounds toward minus infinity.
  assign full   = PROD_W'(gain) * PROD_W'(sig);
  assign scaled = full >>> awpid_pkg::FRAC_BITS;

  always_comb begin
    if (scaled[PROD_W-1:awpid_pkg::ACC_W-1] == '0 ||
        scaled[PROD_W-1:awpid_pkg::ACC_W-1] == '1) begin
      prod = scaled[awpid_pkg::ACC_W-1:0];
    end else begin
      prod = scaled[PROD_W-1] ? awpid_pkg::ACC_MIN : awpid_pkg::ACC_MAX;
    end
  end

endmodule
`default_nettype wire

// ----- src/antiwindup_pid_filtered_derivative_unit.sv -----
// PID position controller with filtered derivative and back-calculation anti-windup.
// Datapath: an accepted sample waits in the input register, the controller arithmetic
// is combinational from it, and the command is registered when the sample moves on.
// Throughput: one sample per cycle while the receiver takes results; the loop through
// the state (gain multiplies, saturating sums and the output clamp) is combinational.
// Reset (rst_n low, synchronous): gains and limits return to their defaults, all
// loop state clears to zero and both pipeline registers are emptied.
`default_nettype none
module antiwindup_pid_filtered_derivative_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  awpid_in_if.sink          in_ch,
  awpid_out_if.source       out_ch,
  awpid_cfg_if.sink         cfg_ch
);

  localparam int SIG_W  = awpid_pkg::SIG_W;
  localparam int ACC_W  = awpid_pkg::ACC_W;
  localparam int ERR_W  = awpid_pkg::ERR_W;
  localparam int DIFF_W = awpid_pkg::DIFF_W;
  localparam int GAIN_W = awpid_pkg::GAIN_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land directly in the registers, so the port
  // is always ready. An index beyond the register list is dropped.
  // ---------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] prop_gain_r, integral_gain_r, windup_gain_r;
  logic signed [GAIN_W-1:0] deriv_pole_r, deriv_gain_r;
  logic signed [SIG_W-1:0]  upper_limit_r, lower_limit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= awpid_pkg::PROP_GAIN_RST;
      integral_gain_r <= awpid_pkg::INTEGRAL_GAIN_RST;
      windup_gain_r   <= awpid_pkg::WINDUP_GAIN_RST;
      deriv_pole_r    <= awpid_pkg::DERIV_POLE_RST;
      deriv_gain_r    <= awpid_pkg::DERIV_GAIN_RST;
      upper_limit_r   <= awpid_pkg::UPPER_LIMIT_RST;
      lower_limit_r   <= awpid_pkg::LOWER_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (awpid_pkg::cfg_reg_t'(cfg_ch.index))
        awpid_pkg::REG_PROP_GAIN:     prop_gain_r     <= cfg_ch.data;
        awpid_pkg::REG_INTEGRAL_GAIN: integral_gain_r <= cfg_ch.data;
        awpid_pkg::REG_WINDUP_GAIN:   windup_gain_r   <= cfg_ch.data;
        awpid_pkg::REG_DERIV_POLE:    deriv_pole_r    <= cfg_ch.data;
        awpid_pkg::REG_DERIV_GAIN:    deriv_gain_r    <= cfg_ch.data;
        awpid_pkg::REG_UPPER_LIMIT:   upper_limit_r   <= cfg_ch.data[SIG_W-1:0];
        awpid_pkg::REG_LOWER_LIMIT:   lower_limit_r   <= cfg_ch.data[SIG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. The input register holds one sample; it moves into the
  // result register whenever that register is empty or its beat is being
  // taken this cycle. The input side stays open as long as the held sample
  // moves on, so a new beat can enter in every cycle.
  // ---------------------------------------------------------------------------
  logic in_valid_r, in_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_acc, advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input sample register.
  logic signed [SIG_W-1:0] ref_r, meas_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ref_r  <= in_ch.reference;
      meas_r <= in_ch.measured_position;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller datapath. The error is formed one bit wider than the samples,
  // so it never saturates. All five gain products are formed side by side;
  // the integral, derivative and output sums follow, each saturating.
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  last_error_r;
  logic signed [ACC_W-1:0]  integral_sum_r, filtered_deriv_r, clip_difference_r;

  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] err_step;
  logic signed [ACC_W-1:0]  err_ext, last_err_ext, err_step_ext;
  logic signed [ACC_W-1:0]  p_term, ki_prod, kt_prod, ad_prod, bd_prod;
  logic signed [ACC_W-1:0]  integ_part, integ_nxt, deriv_nxt, pi_sum, v_sum;
  logic signed [ACC_W-1:0]  hi_ext, lo_ext, u_ext, clip_diff_nxt;
  logic signed [SIG_W-1:0]  drive_nxt;
  logic                     clip_nxt;

  assign err          = ERR_W'(ref_r) - ERR_W'(meas_r);
  assign err_step     = DIFF_W'(err) - DIFF_W'(last_error_r);
  assign err_ext      = ACC_W'(err);
  assign last_err_ext = ACC_W'(last_error_r);
  assign err_step_ext = ACC_W'(err_step);

  awpid_fmul u_mul_p  (.gain(prop_gain_r),     .sig(err_ext),           .prod(p_term));
  awpid_fmul u_mul_ki (.gain(integral_gain_r), .sig(last_err_ext),      .prod(ki_prod));
  awpid_fmul u_mul_kt (.gain(windup_gain_r),   .sig(clip_difference_r), .prod(kt_prod));
  awpid_fmul u_mul_ad (.gain(deriv_pole_r),    .sig(filtered_deriv_r),  .prod(ad_prod));
  awpid_fmul u_mul_bd (.gain(deriv_gain_r),    .sig(err_step_ext),      .prod(bd_prod));

  // The integral takes the previous error and the previous clamp difference
  // (back-calculation), both added one at a time with saturation.
  assign integ_part = awpid_pkg::sat_add(integral_sum_r, ki_prod);
  assign integ_nxt  = awpid_pkg::sat_add(integ_part, kt_prod);
  assign deriv_nxt  = awpid_pkg::sat_add(ad_prod, bd_prod);
  assign pi_sum     = awpid_pkg::sat_add(p_term, integ_nxt);
  assign v_sum      = awpid_pkg::sat_add(pi_sum, deriv_nxt);

  assign hi_ext = ACC_W'(upper_limit_r);
  assign lo_ext = ACC_W'(lower_limit_r);

  // The upper limit is tested first. With crossed limits the command is
  // therefore always one of the two limits. An unclipped value lies between
  // the limits and so fits the output width.
  always_comb begin
    if (v_sum > hi_ext) begin
      drive_nxt = upper_limit_r;
      clip_nxt  = 1'b1;
    end else if (v_sum < lo_ext) begin
      drive_nxt = lower_limit_r;
      clip_nxt  = 1'b1;
    end else begin
      drive_nxt = v_sum[SIG_W-1:0];
      clip_nxt  = 1'b0;
    end
  end

  assign u_ext         = ACC_W'(drive_nxt);
  assign clip_diff_nxt = awpid_pkg::sat_sub(u_ext, v_sum);

  // Loop state advances exactly when a sample moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r      <= '0;
      integral_sum_r    <= '0;
      filtered_deriv_r  <= '0;
      clip_difference_r <= '0;
    end else if (advance) begin
      last_error_r      <= err;
      integral_sum_r    <= integ_nxt;
      filtered_deriv_r  <= deriv_nxt;
      clip_difference_r <= clip_diff_nxt;
    end
  end

  // Result register.
  logic signed [SIG_W-1:0] drive_r;
  logic                    clipped_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r   <= drive_nxt;
      clipped_r <= clip_nxt;
    end
  end

  assign out_ch.drive_value = drive_r;
  assign out_ch.clipped     = clipped_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_valid_r)
    else $error("accepted beat did not reach the input register");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("sample moved on but no result is presented");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(integral_sum_r) && $stable(filtered_deriv_r) &&
                  $stable(clip_difference_r) && $stable(last_error_r)))
    else $error("loop state changed without a sample moving on");

  a_unclipped_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !clip_nxt) |-> (u_ext == v_sum && clip_diff_nxt == '0))
    else $error("unclipped command differs from the unsaturated sum");

endmodule
`default_nettype wire

// ----- test/antiwindup_pid_filtered_derivative_unit_tb.sv -----
// Self-checking testbench for the anti-windup PID unit with a filtered derivative term.
`timescale 1ns / 1ps
module antiwindup_pid_filtered_derivative_unit_tb;
  import awpid_pkg::*;

  // Cycles without any accepted beat, on any channel, before the run is declared hung.
  // The longest intended quiet stretch is the receiver hold-off.
  localparam int STALL_LIMIT = 5000;
  // Extra edges waited after the last predicted result has arrived, as a margin.
  localparam int DRAIN_CYCLES = 8;
  // Register index that the block does not implement; writes to it must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  localparam longint ACC_HI = 2147483647;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic signed [SIG_W-1:0] SIG_TOP = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_BOT = {1'b1, {(SIG_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0] GAIN_TOP = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_BOT = {1'b1, {(GAIN_W-1){1'b0}}};

  // One expected result beat.
  typedef struct packed {
    logic signed [SIG_W-1:0] drive;
    logic                    clipped;
  } drive_command_t;

  logic clk;
  logic rst_n;

  awpid_in_if  in_ch();
  awpid_out_if out_ch();
  awpid_cfg_if cfg_ch();

  antiwindup_pid_filtered_derivative_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Commands predicted for accepted samples, oldest first.
  drive_command_t pending_commands[$];
  int mismatch_count = 0;

  // Traffic shaping knobs, changed by the test tasks between phases, and the watchdog count.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // Position of the simulated target used for well-formed tracking sequences.
  int track_pos = 0;

  // The predictor keeps its own copy of the gains, limits and loop state.
  logic signed [GAIN_W-1:0] kp_q, ki_q, kt_q, ad_q, bd_q;
  logic signed [SIG_W-1:0]  upper_q, lower_q;
  logic signed [ACC_W-1:0]  last_err_q, integ_q, deriv_q, clip_diff_q;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor arithmetic. Everything is carried in 64 bits and clamped back to
  // the signed 32-bit accumulator range after every product, sum and difference.
  // ---------------------------------------------------------------------------
  function automatic longint clamp_acc(input longint x);
    if (x > ACC_HI) return ACC_HI;
    if (x < ACC_LO) return ACC_LO;
    return x;
  endfunction

  // Gain times signal: exact product, arithmetic shift (floor) by the fraction
  // width, then clamped.
  function automatic longint scaled_product(input longint g, input longint s);
    longint prod;
    prod = g * s;
    return clamp_acc(prod >>> FRAC_BITS);
  endfunction

  // Computes the command that one sample produces and advances the loop state.
  function automatic void predict_drive_command(input logic signed [SIG_W-1:0] r,
                                                input logic signed [SIG_W-1:0] m);
    longint err, p_term, i_term, d_term, v_raw, u_out;
    drive_command_t cmd;
    err    = clamp_acc(longint'(r) - longint'(m));
    p_term = scaled_product(longint'(kp_q), err);
    i_term = clamp_acc(longint'(integ_q) + scaled_product(longint'(ki_q), longint'(last_err_q)));
    i_term = clamp_acc(i_term + scaled_product(longint'(kt_q), longint'(clip_diff_q)));
    d_term = clamp_acc(scaled_product(longint'(ad_q), longint'(deriv_q)) +
                       scaled_product(longint'(bd_q),
                                      clamp_acc(err - longint'(last_err_q))));
    v_raw  = clamp_acc(clamp_acc(p_term + i_term) + d_term);

    // The upper limit is tested first, so crossed limits always pick a limit.
    cmd.clipped = 1'b1;
    if (v_raw > longint'(upper_q)) begin
      u_out = longint'(upper_q);
    end else if (v_raw < longint'(lower_q)) begin
      u_out = longint'(lower_q);
    end else begin
      u_out = v_raw;
      cmd.clipped = 1'b0;
    end
    cmd.drive = u_out[SIG_W-1:0];
    pending_commands.push_back(cmd);

    clip_diff_q = ACC_W'(clamp_acc(u_out - v_raw));
    last_err_q  = ACC_W'(err);
    integ_q     = ACC_W'(i_term);
    deriv_q     = ACC_W'(d_term);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel monitor: applies register writes, predicts on every accepted sample
  // and compares every accepted result with the oldest prediction. Results are
  // checked before a new prediction is queued, so a beat on the output can never
  // be matched against the sample accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : track_channels
    drive_command_t want;
    if (!rst_n) begin
      kp_q        = PROP_GAIN_RST;
      ki_q        = INTEGRAL_GAIN_RST;
      kt_q        = WINDUP_GAIN_RST;
      ad_q        = DERIV_POLE_RST;
      bd_q        = DERIV_GAIN_RST;
      upper_q     = UPPER_LIMIT_RST;
      lower_q     = LOWER_LIMIT_RST;
      last_err_q  = '0;
      integ_q     = '0;
      deriv_q     = '0;
      clip_diff_q = '0;
      quiet_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_commands.size() == 0) begin
          $display("%0t: unexpected result beat drive_value %0d clipped %0b",
                   $time, out_ch.drive_value, out_ch.clipped);
          mismatch_count++;
        end else begin
          want = pending_commands.pop_front();
          if (out_ch.drive_value !== want.drive) begin
            $display("%0t: drive_value expected %0d actual %0d",
                     $time, want.drive, out_ch.drive_value);
            mismatch_count++;
          end
          if (out_ch.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0b actual %0b",
                     $time, want.clipped, out_ch.clipped);
            mismatch_count++;
          end
        end
      end

      // Limit registers take only the low bits of the write data.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PROP_GAIN:     kp_q    = cfg_ch.data;
          REG_INTEGRAL_GAIN: ki_q    = cfg_ch.data;
          REG_WINDUP_GAIN:   kt_q    = cfg_ch.data;
          REG_DERIV_POLE:    ad_q    = cfg_ch.data;
          REG_DERIV_GAIN:    bd_q    = cfg_ch.data;
          REG_UPPER_LIMIT:   upper_q = cfg_ch.data[SIG_W-1:0];
          REG_LOWER_LIMIT:   lower_q = cfg_ch.data[SIG_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        predict_drive_command(in_ch.reference, in_ch.measured_position);
      end

      // Watchdog: any accepted beat on any channel proves progress.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result receiver. A requested hold-off keeps ready low until the hold_left count runs
  // out; otherwise ready drops at random with the current stall percentage.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one sample beat and returns at the edge where it was accepted. Valid
  // is only lowered inside an idle gap, so back-to-back beats keep it high.
  task automatic send_sample(input logic signed [SIG_W-1:0] r,
                             input logic signed [SIG_W-1:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.reference         <= r;
    in_ch.measured_position <= m;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Offers one register write beat; the caller lowers valid after the batch.
  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] word);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Stops offering samples and waits until every predicted command has arrived,
  // then waits out the drain margin so that the pipeline is certainly empty.
  task automatic settle_pipeline();
    in_ch.valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all seven registers. The limits get random junk in the unused upper
  // bits of the data word, which the block must ignore.
  task automatic load_settings(input logic signed [GAIN_W-1:0] kp, ki, kt, ad, bd,
                               input logic signed [SIG_W-1:0] upper, lower);
    logic [GAIN_W-SIG_W-1:0] junk_hi, junk_lo;
    junk_hi = (GAIN_W-SIG_W)'($urandom());
    junk_lo = (GAIN_W-SIG_W)'($urandom());
    settle_pipeline();
    put_reg(REG_PROP_GAIN, kp);
    put_reg(REG_INTEGRAL_GAIN, ki);
    put_reg(REG_WINDUP_GAIN, kt);
    put_reg(REG_DERIV_POLE, ad);
    put_reg(REG_DERIV_GAIN, bd);
    put_reg(REG_UPPER_LIMIT, {junk_hi, upper});
    put_reg(REG_LOWER_LIMIT, {junk_lo, lower});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [SIG_W-1:0] corner_value();
    case ($urandom_range(4))
      0:       return SIG_TOP;
      1:       return SIG_BOT;
      2:       return '0;
      3:       return '1;
      default: return 1;
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] wild_gain();
    case ($urandom_range(4))
      0:       return GAIN_TOP;
      1:       return GAIN_BOT;
      2:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom();
    endcase
  endfunction

  // Mostly a moving target followed closely by the measurement, which keeps the
  // loop state in its working range; the rest are corner values and raw noise.
  task automatic make_sample(output logic signed [SIG_W-1:0] r,
                             output logic signed [SIG_W-1:0] m);
    int mode, mv;
    mode = $urandom_range(99);
    if (mode < 70) begin
      track_pos = track_pos + int'($urandom_range(0, 4000)) - 2000;
      if (track_pos > int'(SIG_TOP) || track_pos < int'(SIG_BOT)) track_pos = 0;
      mv = track_pos + int'($urandom_range(0, 131072)) - 65536;
      if (mv > int'(SIG_TOP)) mv = int'(SIG_TOP);
      if (mv < int'(SIG_BOT)) mv = int'(SIG_BOT);
      r = SIG_W'(track_pos);
      m = SIG_W'(mv);
    end else if (mode < 85) begin
      r = corner_value();
      m = corner_value();
    end else begin
      r = SIG_W'($urandom());
      m = SIG_W'($urandom());
    end
  endtask

  // Picks one of three kinds of settings: the reset defaults, a plausible tuned
  // controller, or wild gains and limits that may cross.
  task automatic load_random_settings(input int kind);
    logic signed [SIG_W-1:0] hi, lo;
    case (kind)
      0: begin
        load_settings(PROP_GAIN_RST, INTEGRAL_GAIN_RST, WINDUP_GAIN_RST, DERIV_POLE_RST,
                      DERIV_GAIN_RST, UPPER_LIMIT_RST, LOWER_LIMIT_RST);
      end
      1: begin
        hi = SIG_W'($urandom_range(1 << 16, 10 << 16));
        lo = SIG_W'(-$signed($urandom_range(1 << 16, 10 << 16)));
        load_settings($urandom_range(0, 16 << 16), $urandom_range(0, 1 << 16),
                      $urandom_range(0, 1 << 16), $urandom_range(0, 65535),
                      $urandom_range(0, 256 << 16), hi, lo);
      end
      default: begin
        hi = SIG_W'($urandom());
        lo = SIG_W'($urandom());
        load_settings(wild_gain(), wild_gain(), wild_gain(), wild_gain(), wild_gain(),
                      hi, lo);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Samples against the reset settings: zero, small steps and signal extremes on
  // both inputs; the extremes drive the output into both limits.
  task automatic test_reset_defaults();
    send_sample(0, 0);
    send_sample(SIG_W'(1 << 16), 0);
    send_sample(0, SIG_W'(1 << 16));
    send_sample(SIG_TOP, SIG_BOT);
    send_sample(SIG_BOT, SIG_TOP);
    send_sample(SIG_TOP, SIG_TOP);
    send_sample(SIG_W'(-1), 0);
  endtask

  // Largest and smallest gains with the widest limits push the products and sums
  // into 32-bit saturation in both directions.
  task automatic test_saturation();
    load_settings(GAIN_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, SIG_TOP, SIG_BOT);
    send_sample(SIG_TOP, SIG_BOT);
    send_sample(SIG_TOP, SIG_BOT);
    send_sample(SIG_BOT, SIG_TOP);
    send_sample(SIG_BOT, SIG_TOP);
    load_settings(GAIN_BOT, GAIN_BOT, GAIN_BOT, GAIN_BOT, GAIN_BOT, SIG_TOP, SIG_BOT);
    send_sample(SIG_TOP, SIG_BOT);
    send_sample(SIG_BOT, SIG_TOP);
    send_sample(0, 0);
  endtask

  // Lower limit above upper limit: the command must always sit on a limit.
  task automatic test_crossed_limits();
    load_settings(PROP_GAIN_RST, INTEGRAL_GAIN_RST, WINDUP_GAIN_RST, DERIV_POLE_RST,
                  DERIV_GAIN_RST, SIG_W'(-(1 << 16)), SIG_W'(1 << 16));
    send_sample(0, 0);
    send_sample(SIG_TOP, 0);
    send_sample(SIG_BOT, 0);
    send_sample(100, 0);
  endtask

  // A write to an unimplemented index must leave every register untouched.
  // Equal limits pin the command to one value.
  task automatic test_ignored_index();
    load_settings(PROP_GAIN_RST, INTEGRAL_GAIN_RST, WINDUP_GAIN_RST, DERIV_POLE_RST,
                  DERIV_GAIN_RST, 0, 0);
    @(posedge clk);
    put_reg(REG_SPARE, $urandom());
    cfg_ch.valid <= 1'b0;
    send_sample(SIG_W'(1 << 16), 0);
    send_sample(0, SIG_W'(1 << 16));
    send_sample(0, 0);
  endtask

  // One idling phase: two settings, each followed by a run of random samples.
  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int first_kind, input int count);
    logic signed [SIG_W-1:0] r, m;
    for (int half = 0; half < 2; half++) begin
      load_random_settings((first_kind + half) % 3);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int k = 0; k < count; k++) begin
        make_sample(r, m);
        send_sample(r, m);
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  endtask

  // The receiver refuses results for a long stretch while samples keep coming,
  // so the block fills up and must hold off its input.
  task automatic test_output_backpressure();
    logic signed [SIG_W-1:0] r, m;
    load_random_settings(1);
    hold_left = 300;
    for (int k = 0; k < 40; k++) begin
      make_sample(r, m);
      send_sample(r, m);
    end
  endtask

  initial begin
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.reference         <= '0;
    in_ch.measured_position <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= '0;
    cfg_ch.data             <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_saturation();
    test_crossed_limits();
    test_ignored_index();
    test_random_phase(0, 0, 0, 65);
    test_random_phase(68, 0, 1, 65);
    test_random_phase(0, 68, 2, 65);
    test_random_phase(35, 35, 1, 65);
    test_output_backpressure();

    // Let every outstanding result arrive; the watchdog bounds this wait.
    settle_pipeline();
    if (pending_commands.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_commands.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/awpid_pkg.sv
src/awpid_ifs.sv
src/awpid_fmul.sv
src/antiwindup_pid_filtered_derivative_unit.sv
test/antiwindup_pid_filtered_derivative_unit_tb.sv
